@@ hw/rtl/utf8_stream_decoder_assert.svh @@
// Assertion macros shared by the decoder RTL.
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define U8SD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define U8SD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/u8sd_pkg.sv @@
`timescale 1ns / 1ps

package u8sd_pkg;

    localparam int NumSlots = 3;
    localparam int CpWidth  = 21;

    localparam logic [CpWidth-1:0] Replacement = 21'h00FFFD;

    typedef struct packed {
        logic [CpWidth-1:0] code_point;
        logic               is_replacement;
        logic               last_of_run;
    } result_t;

    typedef struct packed {
        logic [1:0]                count;
        result_t [NumSlots-1:0]    slot;
    } dec_out_t;

    typedef struct packed {
        logic               emit;
        logic               is_replacement;
        logic [CpWidth-1:0] code_point;
        logic               opens;
        logic [CpWidth-1:0] partial;
        logic [1:0]         remaining;
    } lead_t;

    function automatic lead_t lead_decode(input logic [7:0] b);
        lead_t ld;
        ld = '0;
        if (b[7] == 1'b0) begin
            ld.emit       = 1'b1;
            ld.code_point = {13'd0, b};
        end else if (b[7:5] == 3'b110) begin
            ld.opens     = 1'b1;
            ld.partial   = {16'd0, b[4:0]};
            ld.remaining = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
            ld.opens     = 1'b1;
            ld.partial   = {17'd0, b[3:0]};
            ld.remaining = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
            ld.opens     = 1'b1;
            ld.partial   = {18'd0, b[2:0]};
            ld.remaining = 2'd3;
        end else begin
            ld.emit           = 1'b1;
            ld.is_replacement = 1'b1;
            ld.code_point     = Replacement;
        end
        return ld;
    endfunction

endpackage

@@ hw/rtl/u8sd_decode.sv @@
`timescale 1ns / 1ps

module u8sd_decode
    import u8sd_pkg::*;
(
    input  logic [7:0]         text_byte,
    input  logic               end_of_text,
    input  logic [CpWidth-1:0] partial,
    input  logic [1:0]         remaining,
    output logic [CpWidth-1:0] partial_next,
    output logic [1:0]         remaining_next,
    output dec_out_t           dec
);

    lead_t      ld;
    logic [1:0] n;
    logic       do_lead;

    assign ld = lead_decode(text_byte);

    always_comb begin
        dec            = '0;
        n              = '0;
        do_lead        = 1'b0;
        partial_next   = partial;
        remaining_next = remaining;

        if (remaining != 2'd0) begin
            if (text_byte[7:6] == 2'b10) begin
                partial_next   = {partial[CpWidth-7:0], text_byte[5:0]};
                remaining_next = remaining - 2'd1;
                if (remaining_next == 2'd0) begin
                    dec.slot[n].code_point = partial_next;
                    n            = n + 2'd1;
                    partial_next = '0;
                end
            end else begin
                dec.slot[n].code_point     = Replacement;
                dec.slot[n].is_replacement = 1'b1;
                n              = n + 2'd1;
                partial_next   = '0;
                remaining_next = 2'd0;
                do_lead        = 1'b1;
            end
        end else begin
            do_lead = 1'b1;
        end

        if (do_lead) begin
            if (ld.emit) begin
                dec.slot[n].code_point     = ld.code_point;
                dec.slot[n].is_replacement = ld.is_replacement;
                n = n + 2'd1;
            end
            if (ld.opens) begin
                partial_next   = ld.partial;
                remaining_next = ld.remaining;
            end
        end

        // sequence still open at end of text
        if (end_of_text && remaining_next != 2'd0) begin
            dec.slot[n].code_point     = Replacement;
            dec.slot[n].is_replacement = 1'b1;
            n              = n + 2'd1;
            partial_next   = '0;
            remaining_next = 2'd0;
        end

        if (n != 2'd0) begin
            dec.slot[n - 2'd1].last_of_run = 1'b1;
        end
        dec.count = n;
    end

endmodule

@@ hw/rtl/u8sd_out_buf.sv @@
`timescale 1ns / 1ps

`include "utf8_stream_decoder_assert.svh"

module u8sd_out_buf
    import u8sd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     load,
    input  dec_out_t dec,
    output logic     can_load,
    output logic     out_valid,
    input  logic     out_ready,
    output result_t  out_result
);

    result_t [NumSlots-1:0] slot_reg;
    logic [1:0]             cnt_reg, cnt_next;
    logic [1:0]             rd_reg, rd_next;
    logic                   take;

    assign out_valid  = (cnt_reg != 2'd0);
    assign take       = out_valid && out_ready;
    assign can_load   = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_ready);
    assign out_result = slot_reg[rd_reg];

    always_comb begin
        cnt_next = cnt_reg;
        rd_next  = rd_reg;
        if (load) begin
            cnt_next = dec.count;
            rd_next  = 2'd0;
        end else if (take) begin
            cnt_next = cnt_reg - 2'd1;
            rd_next  = rd_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            rd_reg  <= '0;
        end else begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            slot_reg <= dec.slot;
        end
    end

    `U8SD_ASSERT_NOW(a_last_on_final, aclk, aresetn, cnt_reg == 2'd1, out_result.last_of_run, "final result of a byte lacks last flag")
    `U8SD_ASSERT_NOW(a_no_early_last, aclk, aresetn, cnt_reg > 2'd1, !out_result.last_of_run, "last flag set before final result")
    `U8SD_ASSERT_NOW(a_load_when_free, aclk, aresetn, load, can_load, "result buffer overwritten while occupied")

endmodule

@@ hw/rtl/utf8_stream_decoder.sv @@
`timescale 1ns / 1ps

// Channel  | Dir | tdata                       | tuser             | tlast
// s_       | in  | [7:0] text_byte             | -                 | end_of_text
// m_       | out | [20:0] code_point, 0 padded | [0] is_replacement| last_of_run
//
// One byte is accepted per cycle while m_tready is high and each byte gives
// at most one result. A byte that gives two results holds the input while
// more than one of them waits in the buffer; the result buffer drains one transfer per cycle
// while m_tready is high. Each byte passes the input register, then the
// result buffer. aresetn is synchronous; it clears both valid stages
// and the partial code point. m_tready low stalls the buffer and, one byte
// later, the input.

`include "utf8_stream_decoder_assert.svh"

module utf8_stream_decoder
    import u8sd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] zero
    output logic        m_tuser,   // [0] is_replacement
    output logic        m_tlast
);

    logic               s1_valid_reg;
    logic [7:0]         s1_byte_reg;
    logic               s1_eot_reg;
    logic [CpWidth-1:0] partial_reg, partial_next;
    logic [1:0]         remaining_reg, remaining_next;
    dec_out_t           dec;
    logic               can_load;
    logic               advance;
    result_t            res;

    assign advance  = s1_valid_reg && can_load;
    assign s_tready = !s1_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            partial_reg   <= '0;
            remaining_reg <= '0;
        end else begin
            if (s_tready) begin
                s1_valid_reg <= s_tvalid;
            end
            if (advance) begin
                partial_reg   <= partial_next;
                remaining_reg <= remaining_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            s1_byte_reg <= s_tdata;
            s1_eot_reg  <= s_tlast;
        end
    end

    u8sd_decode u_decode (
        .text_byte      (s1_byte_reg),
        .end_of_text    (s1_eot_reg),
        .partial        (partial_reg),
        .remaining      (remaining_reg),
        .partial_next   (partial_next),
        .remaining_next (remaining_next),
        .dec            (dec)
    );

    u8sd_out_buf u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (advance),
        .dec        (dec),
        .can_load   (can_load),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (res)
    );

    assign m_tdata = {3'b000, res.code_point};
    assign m_tuser = res.is_replacement;
    assign m_tlast = res.last_of_run;

    `U8SD_ASSERT_NEXT(a_eot_closes, aclk, aresetn, advance && s1_eot_reg, remaining_reg == 2'd0, "sequence left open after end of text")
    `U8SD_ASSERT_NEXT(a_silent_mid_seq, aclk, aresetn, advance && dec.count == 2'd0, remaining_reg != 2'd0, "byte dropped without an open sequence")

endmodule
